>>> rtl/rect_grid_point_query_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grid point query block
// Concurrent checks on clk, disabled or not during reset.
// ----------------------------------------------------------------------------
`ifndef RECT_GRID_POINT_QUERY_DEFINES_SVH
`define RECT_GRID_POINT_QUERY_DEFINES_SVH

`ifndef SYNTH
// check outside reset
`define RGPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check on every edge, reset included
`define RGPQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RGPQ_ASSERT(lbl, prop, msg)
`define RGPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/rgpq_pkg.sv
// ----------------------------------------------------------------------------
// rgpq_pkg
// Types, sizes and codes shared by the grid point query modules.
// ----------------------------------------------------------------------------
package rgpq_pkg;

	// grid sizes must be powers of two, at least two
	localparam int GRID_W       = 32;
	localparam int GRID_H       = 32;
	localparam int BUCKET_SLOTS = 8;
	localparam int MAX_RECTS    = 256;

	localparam int COL_W    = $clog2(GRID_W);
	localparam int ROW_W    = $clog2(GRID_H);
	localparam int BKT_W    = COL_W + ROW_W;
	localparam int NBUCKETS = GRID_W * GRID_H;
	localparam int NX_W     = $clog2(GRID_W + 1);
	localparam int NY_W     = $clog2(GRID_H + 1);

	localparam int SLOT_W     = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
	localparam int FILL_W     = $clog2(BUCKET_SLOTS + 1);
	localparam int SLOT_DEPTH = NBUCKETS * (1 << SLOT_W);

	localparam int RIDX_W = $clog2(MAX_RECTS);
	localparam int CNT_W  = $clog2(MAX_RECTS + 1);

	localparam int COORD_W   = 16;
	localparam int CELL_W    = 12;
	localparam int MARGIN_W  = 10;
	localparam int QUO_W     = 14;
	localparam int RCOUNT_W  = 9;
	localparam int CFG_IDX_W = 1;

	localparam logic [CELL_W-1:0] MIN_CELL   = 12'd8;
	localparam logic [CELL_W-1:0] CELL_RESET = 12'd32;

	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 1'd1;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_ADD   = 2'd1,
		FUNC_QUERY = 2'd2
	} func_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_WALK_SETUP,
		ST_WALK_RD,
		ST_WALK_WR,
		ST_Q_FILL,
		ST_Q_N,
		ST_Q_SLOT,
		ST_Q_RECT,
		ST_Q_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]                 func;
		logic signed [COORD_W-1:0] rect_left;
		logic signed [COORD_W-1:0] rect_top;
		logic signed [COORD_W-1:0] rect_right;
		logic signed [COORD_W-1:0] rect_bottom;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
	} in_t;

	typedef struct packed {
		logic                hit;
		logic                stored;
		logic                overflow;
		logic [RCOUNT_W-1:0] rect_count;
	} out_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] l;
		logic signed [COORD_W-1:0] t;
		logic signed [COORD_W-1:0] r;
		logic signed [COORD_W-1:0] b;
	} rect_t;

	typedef struct packed {
		logic                      start;
		logic signed [COORD_W-1:0] dividend;
		logic [CELL_W-1:0]         divisor;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> rtl/rgpq_ram.sv
// ----------------------------------------------------------------------------
// rgpq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rgpq_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/rgpq_div.sv
// ----------------------------------------------------------------------------
// rgpq_div
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module rgpq_div import rgpq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int MAG_W  = COORD_W + 1;
	localparam int STEP_W = $clog2(MAG_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic              neg_q;
	logic [MAG_W-1:0]  quo_q;
	logic [CELL_W-1:0] rem_q;
	logic [CELL_W-1:0] dvs_q;

	logic [CELL_W:0]    trial;
	logic [CELL_W:0]    diff;
	logic               ge;
	logic [MAG_W-1:0]   ext;
	logic [QUO_W-1:0]   qmag;

	assign trial = {rem_q, quo_q[MAG_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};
	assign ext   = {req.dividend[COORD_W-1], req.dividend};
	assign qmag  = quo_q[QUO_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[COORD_W-1];
			quo_q <= req.dividend[COORD_W-1] ? (~ext + 1'b1) : ext;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CELL_W-1:0] : trial[CELL_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = $signed(neg_q ? (~qmag + 1'b1) : qmag);

endmodule

>>> rtl/rect_grid_point_query.sv
// ----------------------------------------------------------------------------
// rect_grid_point_query
// Uniform-grid obstacle index: clear, add rectangle, query point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one command per
//   transaction; every command returns exactly one result transaction on the
//   output channel (out_valid / out_stall / out_data).
//   Configuration writes (cfg_valid / cfg_ready / cfg_index / cfg_data) are
//   taken at any time; issue them only while no command is in flight.
//   One command is processed at a time. Each coordinate division runs on a
//   shared bit-serial divider.
//   Query: two divisions, then a check per bucket slot examined (up to 8 slots).
//   Add: four divisions, then a fill read and write per covered bucket (up to GRID_W*GRID_H buckets).
//   Clear: a sweep over all NBUCKETS (1024) entries of the bucket fill memory.
//   Unused command code: result with hit and stored low.
//   After reset the same sweep runs with in_stall high.
//   A finished result waits in the output register while out_stall is high;
//   the next command is taken meanwhile, but its result waits for the slot.
// ----------------------------------------------------------------------------
`include "rect_grid_point_query_defines.svh"

module rect_grid_point_query import rgpq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CELL_W-1:0]    cfg_data
);

	state_t state_q, state_d;

	logic [CELL_W-1:0]   cell_q;
	logic [MARGIN_W-1:0] margin_q;
	logic [CNT_W-1:0]    count_q;
	logic                ovf_q;
	logic [BKT_W-1:0]    clr_q;
	logic                reply_q;

	logic [1:0]              func_q;
	rect_t                   opnd_q;
	logic [1:0]              sel_q;
	logic signed [QUO_W-1:0] q_q [4];
	logic [RIDX_W-1:0]       idx_q;
	logic                    all_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic [ROW_W-1:0]        row0_q;
	logic [NX_W-1:0]         i_q;
	logic [NX_W-1:0]         nx_q;
	logic [NY_W-1:0]         j_q;
	logic [NY_W-1:0]         ny_q;
	logic [BKT_W-1:0]        k_q;
	logic [FILL_W-1:0]       n_q;
	logic [FILL_W-1:0]       s_q;
	logic                    res_hit_q;
	logic                    res_stored_q;
	logic                    out_valid_q;
	out_t                    out_q;

	logic              accept;
	logic              out_free;
	rect_t             widened;
	logic              empty;
	logic              full;
	logic [1:0]        div_last;
	logic [CELL_W-1:0] eff_cell;
	logic              fill_full;
	logic              walk_last;
	logic              pt_hit;
	logic [QUO_W:0]    dx;
	logic [QUO_W:0]    dy;
	logic [FILL_W-1:0] n_clamp;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                    fill_we;
	logic [BKT_W-1:0]        fill_waddr;
	logic [FILL_W-1:0]       fill_wdata;
	logic [BKT_W-1:0]        fill_raddr;
	logic [FILL_W-1:0]       fill_rdata;
	logic                    slot_we;
	logic [BKT_W+SLOT_W-1:0] slot_waddr;
	logic [BKT_W+SLOT_W-1:0] slot_raddr;
	logic [RIDX_W-1:0]       slot_rdata;
	logic                    rect_we;
	logic [RIDX_W-1:0]       rect_raddr;
	rect_t                   rect_rdata;

	// edge moved out by the margin, saturated to the 16-bit range
	function automatic logic signed [COORD_W-1:0] widen_edge(
		input logic signed [COORD_W-1:0] v,
		input logic [MARGIN_W-1:0]       m,
		input logic                      down
	);
		logic signed [COORD_W+1:0] s;
		logic signed [COORD_W+1:0] mm;
		logic signed [COORD_W-1:0] res;
		mm = $signed({{(COORD_W+2-MARGIN_W){1'b0}}, m});
		s  = down ? ($signed({{2{v[COORD_W-1]}}, v}) - mm)
		          : ($signed({{2{v[COORD_W-1]}}, v}) + mm);
		if (s[COORD_W+1:COORD_W-1] != 3'b000 && s[COORD_W+1:COORD_W-1] != 3'b111) begin
			res = s[COORD_W+1] ? $signed({1'b1, {(COORD_W-1){1'b0}}})
			                   : $signed({1'b0, {(COORD_W-1){1'b1}}});
		end else begin
			res = s[COORD_W-1:0];
		end
		return res;
	endfunction

	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign eff_cell  = (cell_q < MIN_CELL) ? MIN_CELL : cell_q;
	assign empty     = (opnd_q.l > opnd_q.r) || (opnd_q.t > opnd_q.b);
	assign full      = count_q >= CNT_W'(MAX_RECTS);
	assign div_last  = (func_q == FUNC_ADD) ? 2'd3 : 2'd1;
	assign fill_full = fill_rdata >= FILL_W'(BUCKET_SLOTS);
	assign walk_last = (j_q + 1'b1 == ny_q) && (i_q + 1'b1 == nx_q);
	assign dx        = {q_q[1][QUO_W-1], q_q[1]} - {q_q[0][QUO_W-1], q_q[0]};
	assign dy        = {q_q[3][QUO_W-1], q_q[3]} - {q_q[2][QUO_W-1], q_q[2]};
	assign n_clamp   = (fill_rdata > FILL_W'(BUCKET_SLOTS)) ? FILL_W'(BUCKET_SLOTS)
	                                                        : fill_rdata;
	// query point sits in opnd_q.l (x) and opnd_q.r (y)
	assign pt_hit    = (opnd_q.l >= rect_rdata.l) && (opnd_q.l <= rect_rdata.r) &&
	                   (opnd_q.r >= rect_rdata.t) && (opnd_q.r <= rect_rdata.b);

	assign widened.l = widen_edge(in_data.rect_left,   margin_q, 1'b1);
	assign widened.t = widen_edge(in_data.rect_top,    margin_q, 1'b1);
	assign widened.r = widen_edge(in_data.rect_right,  margin_q, 1'b0);
	assign widened.b = widen_edge(in_data.rect_bottom, margin_q, 1'b0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == BKT_W'(NBUCKETS - 1)) begin
					state_d = reply_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (in_data.func)
						FUNC_CLEAR: state_d = ST_CLEAR;
						FUNC_ADD:   state_d = ST_ADD;
						FUNC_QUERY: state_d = ST_DIV_GO;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_ADD: begin
				state_d = (empty || full) ? ST_DONE : ST_DIV_GO;
			end
			ST_DIV_GO: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					if (sel_q != div_last) begin
						state_d = ST_DIV_GO;
					end else begin
						state_d = (func_q == FUNC_ADD) ? ST_WALK_SETUP : ST_Q_FILL;
					end
				end
			end
			ST_WALK_SETUP: state_d = ST_WALK_RD;
			ST_WALK_RD:    state_d = ST_WALK_WR;
			ST_WALK_WR:    state_d = walk_last ? ST_DONE : ST_WALK_RD;
			ST_Q_FILL:     state_d = ST_Q_N;
			ST_Q_N:        state_d = (n_clamp == '0) ? ST_DONE : ST_Q_SLOT;
			ST_Q_SLOT:     state_d = ST_Q_RECT;
			ST_Q_RECT:     state_d = ST_Q_CMP;
			ST_Q_CMP: begin
				state_d = (pt_hit || (s_q + 1'b1 == n_q)) ? ST_DONE : ST_Q_SLOT;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: handshake, divider and memory ports
	always_comb begin
		in_stall         = (state_q != ST_IDLE);
		cfg_ready        = 1'b1;
		div_req.start    = (state_q == ST_DIV_GO);
		div_req.divisor  = eff_cell;
		case (sel_q)
			2'd0:    div_req.dividend = opnd_q.l;
			2'd1:    div_req.dividend = opnd_q.r;
			2'd2:    div_req.dividend = opnd_q.t;
			default: div_req.dividend = opnd_q.b;
		endcase
		fill_we    = 1'b0;
		fill_waddr = {col_q, row_q};
		fill_wdata = fill_rdata + 1'b1;
		fill_raddr = {col_q, row_q};
		slot_we    = 1'b0;
		slot_waddr = {col_q, row_q, fill_rdata[SLOT_W-1:0]};
		slot_raddr = {k_q, s_q[SLOT_W-1:0]};
		rect_we    = 1'b0;
		rect_raddr = slot_rdata;
		case (state_q)
			ST_CLEAR: begin
				fill_we    = 1'b1;
				fill_waddr = clr_q;
				fill_wdata = '0;
			end
			ST_ADD: begin
				rect_we = !empty && !full;
			end
			ST_WALK_WR: begin
				fill_we = !fill_full;
				slot_we = !fill_full;
			end
			ST_Q_FILL: begin
				fill_raddr = {q_q[0][COL_W-1:0], q_q[1][ROW_W-1:0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q   <= CELL_RESET;
			margin_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CELL_SIZE: cell_q   <= cfg_data;
				CFG_MARGIN:    margin_q <= cfg_data[MARGIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			clr_q   <= '0;
			reply_q <= 1'b0;
			sel_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			s_q     <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					sel_q <= '0;
					if (accept && in_data.func == FUNC_CLEAR) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						clr_q   <= '0;
						reply_q <= 1'b1;
					end
				end
				ST_ADD: begin
					if (!empty) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						sel_q <= sel_q + 1'b1;
					end
				end
				ST_WALK_SETUP: begin
					i_q <= '0;
					j_q <= '0;
				end
				ST_WALK_WR: begin
					if (fill_full) begin
						ovf_q <= 1'b1;
					end
					if (j_q + 1'b1 == ny_q) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_Q_N:   s_q <= '0;
				ST_Q_CMP: s_q <= s_q + 1'b1;
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_hit_q    <= 1'b0;
				res_stored_q <= 1'b0;
				func_q       <= in_data.func;
				if (in_data.func == FUNC_QUERY) begin
					opnd_q.l <= in_data.point_x;
					opnd_q.r <= in_data.point_y;
					opnd_q.t <= in_data.point_y;
					opnd_q.b <= in_data.point_y;
				end else begin
					opnd_q <= widened;
				end
			end
			ST_ADD: begin
				idx_q <= count_q[RIDX_W-1:0];
				all_q <= 1'b1;
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					q_q[sel_q] <= div_rsp.quotient;
				end
			end
			ST_WALK_SETUP: begin
				col_q  <= q_q[0][COL_W-1:0];
				row_q  <= q_q[2][ROW_W-1:0];
				row0_q <= q_q[2][ROW_W-1:0];
				nx_q   <= (dx >= (QUO_W+1)'(GRID_W)) ? NX_W'(GRID_W) : NX_W'(dx + 1'b1);
				ny_q   <= (dy >= (QUO_W+1)'(GRID_H)) ? NY_W'(GRID_H) : NY_W'(dy + 1'b1);
			end
			ST_WALK_WR: begin
				if (fill_full) begin
					all_q <= 1'b0;
				end
				if (j_q + 1'b1 == ny_q) begin
					row_q <= row0_q;
					col_q <= col_q + 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
				end
				if (walk_last) begin
					res_stored_q <= all_q && !fill_full;
				end
			end
			ST_Q_FILL: k_q <= {q_q[0][COL_W-1:0], q_q[1][ROW_W-1:0]};
			ST_Q_N:    n_q <= n_clamp;
			ST_Q_CMP: begin
				if (pt_hit) begin
					res_hit_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q.hit        <= res_hit_q;
			out_q.stored     <= res_stored_q;
			out_q.overflow   <= ovf_q;
			out_q.rect_count <= RCOUNT_W'(count_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	rgpq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	rgpq_ram #(
		.DEPTH (NBUCKETS),
		.WIDTH (FILL_W)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.raddr (fill_raddr),
		.rdata (fill_rdata)
	);

	rgpq_ram #(
		.DEPTH (SLOT_DEPTH),
		.WIDTH (RIDX_W)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (idx_q),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	rgpq_ram #(
		.DEPTH (MAX_RECTS),
		.WIDTH ($bits(rect_t))
	) u_rect_ram (
		.clk   (clk),
		.we    (rect_we),
		.waddr (count_q[RIDX_W-1:0]),
		.wdata (opnd_q),
		.raddr (rect_raddr),
		.rdata (rect_rdata)
	);

	`RGPQ_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "result without finished command")
	`RGPQ_ASSERT_ALWAYS(a_count_max, count_q <= CNT_W'(MAX_RECTS), "rectangle count above store size")
	`RGPQ_ASSERT(a_fill_max, fill_we |-> fill_wdata <= FILL_W'(BUCKET_SLOTS), "bucket fill above slot count")
	`RGPQ_ASSERT(a_div_idle, div_req.start |-> !(state_q == ST_DIV_WAIT), "divider restarted while busy")

endmodule
